/* rtl/segmented_weighted_vector_mean_macros.svh */
// Assertion macros for the segmented weighted vector mean block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef SEGMENTED_WEIGHTED_VECTOR_MEAN_MACROS_SVH
`define SEGMENTED_WEIGHTED_VECTOR_MEAN_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SWVM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SWVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SWVM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SWVM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/swvm_pkg.sv */
// Package for the segmented weighted vector mean block: payload structs, codes, FSM states.
// No dependencies.
`default_nettype none

package swvm_pkg;

    localparam int COMP_W         = 32;
    localparam int WEIGHT_W       = 16;
    localparam int WEIGHT_FRAC    = 6;
    localparam int ACC_W          = 64;
    localparam int VECTOR_DIMS    = 3;
    localparam int DIM_W          = 2;
    localparam int MAX_GROUP_SIZE_DEF = 4096;

    localparam logic [1:0] MODE_GEOM  = 2'd0;
    localparam logic [1:0] MODE_MASS  = 2'd1;
    localparam logic [1:0] MODE_FGEOM = 2'd2;
    localparam logic [1:0] MODE_FSUM  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_MASS = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
        logic [WEIGHT_W-1:0]      weight;
        logic                     group_end;
    } t_in_item;

    typedef struct packed {
        logic signed [COMP_W-1:0] res_x;
        logic signed [COMP_W-1:0] res_y;
        logic signed [COMP_W-1:0] res_z;
        logic [1:0]               status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ITEM,
        S_MACC,
        S_IDIV,
        S_IACC,
        S_FIN,
        S_FML0,
        S_FML1,
        S_FML2,
        S_FDIV,
        S_FPACK,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

/* rtl/segmented_weighted_vector_mean.sv */
// Segmented weighted vector mean: group accumulation of 3-D vectors and per-group result.
// Depends on swvm_pkg and segmented_weighted_vector_mean_macros.svh.
//
// One item at a time; o_in_stall stays high from a transfer until the item is done. All
// divisions go through one restoring divider that retires one quotient bit per cycle, and
// it sets the timing. Per component, modes 0 and 3 add the value, mode 1 adds it times its
// weight, mode 2 adds it over its weight (skipped at zero weight). A group end divides each
// sum by the count (mode 0) or mass (mode 1), scales it by mass and divides by the count
// (mode 2) or packs it (mode 3), then loads the output register, which can hold one
// finished result while the next group streams in. The mode register may only be written while idle.
`default_nettype none

`include "segmented_weighted_vector_mean_macros.svh"

module segmented_weighted_vector_mean
    import swvm_pkg::*;
#(
    parameter int MAX_GROUP_SIZE = MAX_GROUP_SIZE_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    localparam int CNT_W  = $clog2(MAX_GROUP_SIZE + 1);
    localparam int MASS_W = $clog2(longint'(MAX_GROUP_SIZE) * ((longint'(1) << WEIGHT_W) - 1)
                                   + 1);
    localparam int DVS_W  = MASS_W;
    localparam int DVD_W  = ACC_W + MASS_W;
    localparam int IT_W   = $clog2(DVD_W + 1);
    localparam int PROD_W = COMP_W + MASS_W;
    localparam int ITEM_DVD_W = COMP_W + WEIGHT_FRAC;

    t_state                   r_state, n_state;
    logic [1:0]               r_mode;
    t_in_item                 r_item, n_item;
    logic [DIM_W-1:0]         r_dim, n_dim;
    logic [ACC_W-1:0]         r_acc [VECTOR_DIMS];
    logic [MASS_W-1:0]        r_mass, n_mass;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [1:0]               r_err, n_err;
    logic [PROD_W-1:0]        r_prod, n_prod;
    logic [ACC_W-1:0]         r_mag, n_mag;
    logic                     r_neg, n_neg;
    logic [DVS_W-1:0]         r_rem, n_rem;
    logic [DVS_W-1:0]         r_dvs, n_dvs;
    logic [DVD_W-1:0]         r_quo, n_quo;
    logic [IT_W-1:0]          r_it, n_it;
    logic [COMP_W-1:0]        r_res [VECTOR_DIMS];
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;

    logic                     acc_we, res_we, grp_clr, adv;
    logic signed [COMP_W-1:0] comp_sel;
    logic [COMP_W-1:0]        comp_mag;
    logic                     comp_neg;
    logic [ACC_W-1:0]         acc_cur, acc_mag, addend, acc_sum, prod64, qsat64;
    logic                     acc_neg;
    logic [COMP_W-1:0]        q_lim, qsat;
    logic [COMP_W-1:0]        mul_a;
    logic [MASS_W-1:0]        mul_b;
    logic [PROD_W-1:0]        mul_out;
    logic [DVS_W:0]           rem_sh;
    logic [DVS_W+1:0]         rem_diff;
    logic                     rem_ge;
    logic [DVS_W-1:0]         step_rem;
    logic [DVD_W-1:0]         step_quo, pk_mag;
    logic [COMP_W-1:0]        pk_res;
    logic [1:0]               err_eff;
    logic                     out_free, last_dim;

    // ---- datapath helpers ----
    always_comb begin
        case (r_dim)
            DIM_W'(0): comp_sel = r_item.comp_x;
            DIM_W'(1): comp_sel = r_item.comp_y;
            default:   comp_sel = r_item.comp_z;
        endcase
    end

    assign comp_neg = comp_sel[COMP_W-1];
    assign comp_mag = comp_neg ? (~comp_sel + COMP_W'(1)) : comp_sel;

    assign acc_cur  = r_acc[r_dim];
    assign acc_neg  = acc_cur[ACC_W-1];
    assign acc_mag  = acc_neg ? (~acc_cur + ACC_W'(1)) : acc_cur;

    assign last_dim = (r_dim == DIM_W'(VECTOR_DIMS - 1));
    assign out_free = !r_out_valid || !i_out_stall;

    // shared multiplier
    always_comb begin
        unique case (r_state)
            S_FML0: begin
                mul_a = r_mag[COMP_W-1:0];
                mul_b = r_mass;
            end
            S_FML1: begin
                mul_a = r_mag[ACC_W-1:COMP_W];
                mul_b = r_mass;
            end
            default: begin
                mul_a = comp_mag;
                mul_b = MASS_W'(r_item.weight);
            end
        endcase
    end

    assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

    // accumulator addend and shared adder
    assign prod64 = ACC_W'(r_prod);
    assign q_lim  = r_neg ? (COMP_W'(1) << (COMP_W - 1))
                          : ((COMP_W'(1) << (COMP_W - 1)) - COMP_W'(1));
    assign qsat   = (r_quo > DVD_W'(q_lim)) ? q_lim : r_quo[COMP_W-1:0];
    assign qsat64 = ACC_W'(qsat);

    always_comb begin
        unique case (r_state)
            S_MACC:  addend = r_neg ? (~prod64 + ACC_W'(1)) : prod64;
            S_IACC:  addend = r_neg ? (~qsat64 + ACC_W'(1)) : qsat64;
            default: addend = {{(ACC_W - COMP_W){comp_sel[COMP_W-1]}}, comp_sel};
        endcase
    end

    assign acc_sum = acc_cur + addend;

    // restoring divider step
    assign rem_sh   = {r_rem, r_quo[DVD_W-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign rem_ge   = !rem_diff[DVS_W+1];
    assign step_rem = rem_ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    assign step_quo = {r_quo[DVD_W-2:0], rem_ge};

    // saturating pack of sign and magnitude
    assign pk_mag = (r_mode == MODE_FSUM) ? DVD_W'(r_mag) : r_quo;

    always_comb begin
        if (r_neg) begin
            if (pk_mag >= DVD_W'(COMP_W'(1) << (COMP_W - 1))) begin
                pk_res = COMP_W'(1) << (COMP_W - 1);
            end else begin
                pk_res = ~pk_mag[COMP_W-1:0] + COMP_W'(1);
            end
        end else begin
            if (pk_mag > DVD_W'((COMP_W'(1) << (COMP_W - 1)) - COMP_W'(1))) begin
                pk_res = (COMP_W'(1) << (COMP_W - 1)) - COMP_W'(1);
            end else begin
                pk_res = pk_mag[COMP_W-1:0];
            end
        end
    end

    assign err_eff = (r_err != ST_OK) ? r_err :
                     ((r_mode == MODE_MASS && r_mass == '0) ? ST_ZERO_MASS : ST_OK);

    // ---- sequencer ----
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_dim       = r_dim;
        n_mass      = r_mass;
        n_count     = r_count;
        n_err       = r_err;
        n_prod      = r_prod;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_quo       = r_quo;
        n_it        = r_it;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        acc_we      = 1'b0;
        res_we      = 1'b0;
        grp_clr     = 1'b0;
        adv         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in;
                    n_dim  = '0;
                    if (r_count >= CNT_W'(MAX_GROUP_SIZE)) begin
                        if (r_err == ST_OK) begin
                            n_err = ST_TOO_LONG;
                        end
                        n_state = i_in.group_end ? S_FIN : S_IDLE;
                    end else begin
                        if (r_mode == MODE_FGEOM && i_in.weight == '0 && r_err == ST_OK) begin
                            n_err = ST_ZERO_MASS;
                        end
                        n_mass  = r_mass + MASS_W'(i_in.weight);
                        n_count = r_count + CNT_W'(1);
                        n_state = S_ITEM;
                    end
                end
            end
            S_ITEM: begin
                n_neg = comp_neg;
                case (r_mode)
                    MODE_MASS: begin
                        n_prod  = mul_out;
                        n_state = S_MACC;
                    end
                    MODE_FGEOM: begin
                        if (r_item.weight == '0) begin
                            adv = 1'b1;
                        end else begin
                            n_rem   = '0;
                            n_dvs   = DVS_W'(r_item.weight);
                            n_quo   = DVD_W'({comp_mag, WEIGHT_FRAC'(0)}) << (DVD_W - ITEM_DVD_W);
                            n_it    = IT_W'(ITEM_DVD_W);
                            n_state = S_IDIV;
                        end
                    end
                    default: begin
                        acc_we = 1'b1;
                        adv    = 1'b1;
                    end
                endcase
            end
            S_MACC: begin
                acc_we = 1'b1;
                adv    = 1'b1;
            end
            S_IDIV: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_it  = r_it - IT_W'(1);
                if (r_it == IT_W'(1)) begin
                    n_state = S_IACC;
                end
            end
            S_IACC: begin
                acc_we = 1'b1;
                adv    = 1'b1;
            end
            S_FIN: begin
                n_err = err_eff;
                if (err_eff != ST_OK) begin
                    n_dim   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_neg = acc_neg;
                    n_mag = acc_mag;
                    case (r_mode)
                        MODE_GEOM: begin
                            n_rem   = '0;
                            n_dvs   = DVS_W'(r_count);
                            n_quo   = DVD_W'(acc_mag) << (DVD_W - ACC_W);
                            n_it    = IT_W'(ACC_W);
                            n_state = S_FDIV;
                        end
                        MODE_MASS: begin
                            n_rem   = '0;
                            n_dvs   = r_mass;
                            n_quo   = DVD_W'(acc_mag) << (DVD_W - ACC_W);
                            n_it    = IT_W'(ACC_W);
                            n_state = S_FDIV;
                        end
                        MODE_FGEOM: n_state = S_FML0;
                        default:    n_state = S_FPACK;
                    endcase
                end
            end
            S_FML0: begin
                n_prod  = mul_out;
                n_state = S_FML1;
            end
            S_FML1: begin
                n_quo   = DVD_W'(r_prod);
                n_prod  = mul_out;
                n_state = S_FML2;
            end
            S_FML2: begin
                n_quo   = r_quo + (DVD_W'(r_prod) << COMP_W);
                n_rem   = '0;
                n_dvs   = DVS_W'({r_count, WEIGHT_FRAC'(0)});
                n_it    = IT_W'(DVD_W);
                n_state = S_FDIV;
            end
            S_FDIV: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_it  = r_it - IT_W'(1);
                if (r_it == IT_W'(1)) begin
                    n_state = S_FPACK;
                end
            end
            S_FPACK: begin
                res_we = 1'b1;
                if (last_dim) begin
                    n_dim   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_dim   = r_dim + DIM_W'(1);
                    n_state = S_FIN;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.status = r_err;
                    n_out.res_x  = (r_err == ST_OK) ? r_res[0] : '0;
                    n_out.res_y  = (r_err == ST_OK) ? r_res[1] : '0;
                    n_out.res_z  = (r_err == ST_OK) ? r_res[2] : '0;
                    grp_clr      = 1'b1;
                    n_mass       = '0;
                    n_count      = '0;
                    n_err        = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (adv) begin
            if (last_dim) begin
                n_dim   = '0;
                n_state = r_item.group_end ? S_FIN : S_IDLE;
            end else begin
                n_dim   = r_dim + DIM_W'(1);
                n_state = S_ITEM;
            end
        end
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_GEOM;
            r_dim       <= '0;
            r_mass      <= '0;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
            for (int i = 0; i < VECTOR_DIMS; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_dim       <= n_dim;
            r_mass      <= n_mass;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (grp_clr) begin
                for (int i = 0; i < VECTOR_DIMS; i++) begin
                    r_acc[i] <= '0;
                end
            end else if (acc_we) begin
                r_acc[r_dim] <= acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_prod <= n_prod;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quo  <= n_quo;
        r_it   <= n_it;
        r_out  <= n_out;
        if (res_we) begin
            r_res[r_dim] <= pk_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---- assertions ----
    `SWVM_ASSERT_NOW(a_count_limit, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_GROUP_SIZE))
    `SWVM_ASSERT_NOW(a_div_rem, i_clk, i_rst_n, (r_state == S_IDIV || r_state == S_FDIV),
                     (r_rem < r_dvs && r_it != '0))
    `SWVM_ASSERT_NOW(a_err_zero_res, i_clk, i_rst_n, (o_out_valid && o_out.status != ST_OK),
                     (o_out.res_x == '0 && o_out.res_y == '0 && o_out.res_z == '0))
    `SWVM_ASSERT_NEXT(a_group_clear, i_clk, i_rst_n, (r_state == S_EMIT && out_free),
                      (r_count == '0 && r_err == ST_OK && o_out_valid))

endmodule

`default_nettype wire
